/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the servo slew ramp unit.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising edge, skipped while reset is low.
`define DSSR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every rising edge, reset included.
`define DSSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DSSR_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define DSSR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/dssr_pkg.sv */
// Shared types and constants for the dual servo slew ramp unit.
// No dependencies.
`timescale 1ns / 1ps

package dssr_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned SWING_W = 15;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes carried in the mode field
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_NEUTRAL  = 3'd1;
  localparam logic [2:0] MODE_FORWARD  = 3'd2;
  localparam logic [2:0] MODE_BACKWARD = 3'd3;
  localparam logic [2:0] MODE_BOTH_UP  = 3'd4;
  localparam logic [2:0] MODE_BOTH_DN  = 3'd5;
  localparam logic [2:0] MODE_SPLIT    = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWING     = 2'd2;

  localparam logic [POS_W-1:0]   NEUTRAL_RST  = 16'd3000;
  localparam logic [SWING_W-1:0] SWING_RST    = 15'd1000;
  localparam logic [POS_W-1:0]   INTERVAL_RST = 16'd1;

  typedef struct packed {
    logic [POS_W-1:0]   neutral_a;
    logic [POS_W-1:0]   neutral_b;
    logic [SWING_W-1:0] swing;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [POS_W-1:0] amount;
    logic [POS_W-1:0] step_interval;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic [POS_W-1:0] goal_a;
    logic [POS_W-1:0] goal_b;
    logic [POS_W-1:0] interval;
    logic [POS_W-1:0] tick_count;
  } ramp_state_t;

endpackage

/* rtl/dssr_cfg_regs.sv */
// Configuration register file: neutral widths and swing.
// Depends on dssr_pkg.
`timescale 1ns / 1ps

module dssr_cfg_regs
  import dssr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEUTRAL_A: cfg_nxt.neutral_a = cfg_wdata;
        CFG_NEUTRAL_B: cfg_nxt.neutral_b = cfg_wdata;
        CFG_SWING:     cfg_nxt.swing     = cfg_wdata[SWING_W-1:0];
        default:       cfg_nxt = cfg_r;  // unknown index: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neutral_a <= NEUTRAL_RST;
      cfg_r.neutral_b <= NEUTRAL_RST;
      cfg_r.swing     <= SWING_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/dssr_step.sv */
// Next-state logic for one item: goal selection, clamping, divider, one-count step.
// Depends on dssr_pkg.
`timescale 1ns / 1ps

module dssr_step
  import dssr_pkg::*;
(
  input  cfg_t        cfg,
  input  item_t       item,
  input  ramp_state_t cur,
  output ramp_state_t nxt
);

  function automatic logic [POS_W-1:0] win_lo(input logic [POS_W-1:0] n,
                                              input logic [SWING_W-1:0] s);
    logic [POS_W:0] d;
    d = {1'b0, n} - {2'b00, s};
    return d[POS_W] ? '0 : d[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] win_hi(input logic [POS_W-1:0] n,
                                              input logic [SWING_W-1:0] s);
    logic [POS_W:0] h;
    h = {1'b0, n} + {2'b00, s};
    return h[POS_W] ? '1 : h[POS_W-1:0];
  endfunction

  // Exact p +/- amt, then clamp to [lo, hi]
  function automatic logic [POS_W-1:0] clamp_rel(input logic [POS_W-1:0] p,
                                                 input logic [POS_W-1:0] amt,
                                                 input logic             up,
                                                 input logic [POS_W-1:0] lo,
                                                 input logic [POS_W-1:0] hi);
    logic signed [POS_W+1:0] v;
    logic signed [POS_W+1:0] slo;
    logic signed [POS_W+1:0] shi;
    slo = signed'({2'b00, lo});
    shi = signed'({2'b00, hi});
    v = up ? signed'({2'b00, p}) + signed'({2'b00, amt})
           : signed'({2'b00, p}) - signed'({2'b00, amt});
    if (v < slo) v = slo;
    if (v > shi) v = shi;
    return v[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] move_one(input logic [POS_W-1:0] p,
                                                input logic [POS_W-1:0] g);
    logic [POS_W-1:0] r;
    r = p;
    if (g > p)      r = p + 1'b1;
    else if (g < p) r = p - 1'b1;
    return r;
  endfunction

  logic [POS_W-1:0] lo_a, hi_a, lo_b, hi_b;
  logic [POS_W-1:0] tick_inc;
  logic [POS_W-1:0] goal_a, goal_b;
  logic             is_cmd, do_step;

  assign lo_a = win_lo(cfg.neutral_a, cfg.swing);
  assign hi_a = win_hi(cfg.neutral_a, cfg.swing);
  assign lo_b = win_lo(cfg.neutral_b, cfg.swing);
  assign hi_b = win_hi(cfg.neutral_b, cfg.swing);

  assign tick_inc = cur.tick_count + 1'b1;

  always_comb begin
    is_cmd = 1'b1;
    goal_a = cur.goal_a;
    goal_b = cur.goal_b;
    unique case (item.mode)
      MODE_NEUTRAL: begin
        goal_a = cfg.neutral_a;
        goal_b = cfg.neutral_b;
      end
      MODE_FORWARD: begin
        goal_a = hi_a;
        goal_b = lo_b;
      end
      MODE_BACKWARD: begin
        goal_a = lo_a;
        goal_b = hi_b;
      end
      MODE_BOTH_UP: begin
        goal_a = clamp_rel(cur.pos_a, item.amount, 1'b1, lo_a, hi_a);
        goal_b = clamp_rel(cur.pos_b, item.amount, 1'b1, lo_b, hi_b);
      end
      MODE_BOTH_DN: begin
        goal_a = clamp_rel(cur.pos_a, item.amount, 1'b0, lo_a, hi_a);
        goal_b = clamp_rel(cur.pos_b, item.amount, 1'b0, lo_b, hi_b);
      end
      MODE_SPLIT: begin
        goal_a = clamp_rel(cur.pos_a, item.amount, 1'b1, lo_a, hi_a);
        goal_b = clamp_rel(cur.pos_b, item.amount, 1'b0, lo_b, hi_b);
      end
      default: is_cmd = 1'b0;  // tick, and the unused code acts as a tick
    endcase
  end

  always_comb begin
    nxt        = cur;
    nxt.goal_a = goal_a;
    nxt.goal_b = goal_b;
    if (is_cmd) begin
      nxt.interval   = (item.step_interval == '0) ? INTERVAL_RST : item.step_interval;
      nxt.tick_count = '0;
      do_step        = 1'b1;
    end else if (tick_inc >= cur.interval) begin
      nxt.tick_count = '0;
      do_step        = 1'b1;
    end else begin
      nxt.tick_count = tick_inc;
      do_step        = 1'b0;
    end
    if (do_step) begin
      nxt.pos_a = move_one(cur.pos_a, goal_a);
      nxt.pos_b = move_one(cur.pos_b, goal_b);
    end
  end

endmodule

/* rtl/dual_servo_slew_ramp_unit.sv */
// Top level of the dual servo slew ramp unit: handshake pipeline and ramp state.
// Depends on dssr_pkg, dssr_cfg_regs, dssr_step and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in_     | input     | in_valid/in_stall  | in_mode, in_amount, in_step_interval
//   out_    | output    | out_valid/out_stall| out_position_a/_b, out_moving
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One item per clock sustained while no result is held; a taken item goes into the
// input register, then into the result register once that register is free.
// The rate is set by the ramp state loop, which closes through the step logic
// back into the ramp state register.
// Reset (synchronous, rst_n low) empties both pipeline registers, restores the
// neutral/swing defaults and parks both channels at neutral with interval one.
// A held result stalls the input register, which in turn stalls in_ only when
// both registers are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_servo_slew_ramp_unit
  import dssr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // item input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_mode,
  input  logic [POS_W-1:0]     in_amount,
  input  logic [POS_W-1:0]     in_step_interval,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_W-1:0]     out_position_a,
  output logic [POS_W-1:0]     out_position_b,
  output logic                 out_moving,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t        cfg;
  item_t       item_r;
  logic        item_vld_r, item_vld_nxt;
  ramp_state_t st_r, st_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [POS_W-1:0] out_pos_a_r, out_pos_b_r;
  logic             out_moving_r;

  logic in_take, item_fire, out_free;

  dssr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dssr_step u_step (
    .cfg  (cfg),
    .item (item_r),
    .cur  (st_r),
    .nxt  (st_nxt)
  );

  // Result register is free when empty or being drained this cycle
  assign out_free  = !out_vld_r || !out_stall;
  // Advance the held item into the result register and commit its state
  assign item_fire = item_vld_r && out_free;
  // Hold off new items only when the input register cannot move on
  assign in_stall  = item_vld_r && !out_free;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_take)        item_vld_nxt = 1'b1;
    else if (item_fire) item_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (item_fire)       out_vld_nxt = 1'b1;
    else if (!out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r    <= 1'b0;
      out_vld_r     <= 1'b0;
      st_r.pos_a      <= NEUTRAL_RST;
      st_r.pos_b      <= NEUTRAL_RST;
      st_r.goal_a     <= NEUTRAL_RST;
      st_r.goal_b     <= NEUTRAL_RST;
      st_r.interval   <= INTERVAL_RST;
      st_r.tick_count <= '0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (item_fire) st_r <= st_nxt;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode          <= in_mode;
      item_r.amount        <= in_amount;
      item_r.step_interval <= in_step_interval;
    end
    if (item_fire) begin
      out_pos_a_r  <= st_nxt.pos_a;
      out_pos_b_r  <= st_nxt.pos_b;
      out_moving_r <= (st_nxt.pos_a != st_nxt.goal_a) || (st_nxt.pos_b != st_nxt.goal_b);
    end
  end

  assign out_valid      = out_vld_r;
  assign out_position_a = out_pos_a_r;
  assign out_position_b = out_pos_b_r;
  assign out_moving     = out_moving_r;

  // Divider never sits at or past the latched interval, which is never zero
  `DSSR_ASSERT_RST(a_tick_below_interval, clk, rst_n,
                   st_r.tick_count < st_r.interval, "tick count reached interval")
  // Input back-pressure only comes from a held result
  `DSSR_ASSERT_RST(a_stall_cause, clk, rst_n,
                   in_stall |-> (out_vld_r && out_stall && item_vld_r),
                   "input stalled without a held result")
  // An item that leaves the input register always lands as a valid result
  `DSSR_ASSERT_RST(a_fire_lands, clk, rst_n,
                   item_fire |=> out_vld_r, "committed item produced no result")
  // Ramp state changes only when an item commits
  `DSSR_ASSERT_RST(a_state_quiet, clk, rst_n,
                   (!$past(item_fire) && $past(rst_n)) |-> $stable(st_r),
                   "ramp state moved without an item")

endmodule
